### rtl/lri_pkg.sv
// Package for the interpolating line rasterizer: widths, phase codes, shared types.
// No dependencies.
package lri_pkg;
  localparam int unsigned CoordBits = 12;
  localparam int unsigned ColorBits = 24;

  // input command codes
  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_ONE  = 2'd1,
    PHASE_TWO  = 2'd2
  } phase_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture endpoints of a start item
    logic div_start; // start one interpolation
    logic advance;   // commit walk update after a pixel
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic   div_done;
    logic   fin;
    phase_e phase;
  } dp_sts_t;
endpackage

### rtl/lri_datapath.sv
// Datapath of the line rasterizer: endpoint and walk registers, serial divider.
// Depends on lri_pkg.
module lri_datapath #(
  parameter int unsigned CoordBits = lri_pkg::CoordBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lri_pkg::dp_cmd_t                cmd_i,
  output lri_pkg::dp_sts_t                sts_o,
  input  logic signed [CoordBits-1:0]     ax_i,
  input  logic signed [CoordBits-1:0]     ay_i,
  input  logic signed [CoordBits-1:0]     bx_i,
  input  logic signed [CoordBits-1:0]     by_i,
  input  logic [lri_pkg::ColorBits-1:0]   line_color_i,
  output logic signed [CoordBits-1:0]     px_o,
  output logic signed [CoordBits-1:0]     py_o,
  output logic [lri_pkg::ColorBits-1:0]   pixel_color_o
);
  import lri_pkg::*;

  localparam int unsigned WB = CoordBits + 2;    // span / offset width
  localparam int unsigned PB = 2 * WB;           // product magnitude width
  localparam int unsigned CB = $clog2(PB + 1);

  phase_e phase_q, phase_d;
  logic signed [CoordBits-1:0] fx_q, fy_q, sx_q, sy_q;
  logic signed [CoordBits:0]   pos_q;
  logic [ColorBits-1:0]        col_q;
  logic signed [CoordBits-1:0] px_q, py_q;

  // divider
  logic [PB-1:0] rem_q, quo_q;
  logic [WB-1:0] den_q;
  logic          neg_q, busy_q, done_q;
  logic [CB-1:0] cnt_q;
  logic signed [WB-1:0] base_q;

  logic signed [CoordBits-1:0] ax_s, ay_s, bx_s, by_s;
  logic signed [WB-1:0] num_w, den_w, off_w, base_w, cur_w;
  logic [WB-1:0] num_m, den_m, off_m;
  logic [PB-1:0] prod_w;
  logic [PB:0]   trial_w;
  logic [PB-1:0] rem_sh;
  logic signed [WB-1:0] quo_s, res_w;
  logic fin_w;

  always_comb begin
    if (ay_i < by_i) begin
      ax_s = bx_i; ay_s = by_i; bx_s = ax_i; by_s = ay_i;
    end else begin
      ax_s = ax_i; ay_s = ay_i; bx_s = bx_i; by_s = by_i;
    end
  end

  // interpolation operands for the current phase
  always_comb begin
    if (phase_q == PHASE_ONE) begin
      num_w  = WB'(sx_q) - WB'(fx_q);
      den_w  = WB'(sy_q) - WB'(fy_q);
      off_w  = WB'(pos_q) - WB'(fy_q);
      base_w = WB'(fx_q);
    end else begin
      num_w  = WB'(sy_q) - WB'(fy_q);
      den_w  = WB'(sx_q) - WB'(fx_q);
      off_w  = WB'(pos_q) - WB'(fx_q);
      base_w = WB'(fy_q);
    end
    num_m = num_w[WB-1] ? WB'(-num_w) : WB'(num_w);
    off_m = off_w[WB-1] ? WB'(-off_w) : WB'(off_w);
    den_m = (den_w == '0) ? WB'(1) : (den_w[WB-1] ? WB'(-den_w) : WB'(den_w));
    prod_w = PB'(num_m) * PB'(off_m);
  end

  assign rem_sh  = rem_q;
  assign trial_w = {rem_sh, quo_q[PB-1]} - {{(PB + 1 - WB){1'b0}}, den_q};
  assign quo_s   = neg_q ? WB'(-quo_q) : WB'(quo_q);
  assign res_w   = base_q + quo_s;
  assign cur_w   = WB'(pos_q);

  // iteration counter; done pulses the cycle after the last quotient bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.load) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CB'(PB);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CB'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= prod_w;
      den_q  <= den_m;
      neg_q  <= num_w[WB-1] ^ off_w[WB-1] ^ (den_w[WB-1] && den_w != '0);
      base_q <= base_w;
    end else if (busy_q) begin
      if (!trial_w[PB]) begin
        rem_q <= trial_w[PB-1:0];
        quo_q <= {quo_q[PB-2:0], 1'b1};
      end else begin
        rem_q <= {rem_sh[PB-2:0], quo_q[PB-1]};
        quo_q <= {quo_q[PB-2:0], 1'b0};
      end
    end
  end

  // walk update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_IDLE;
      fx_q <= '0; fy_q <= '0; sx_q <= '0; sy_q <= '0;
      pos_q <= '0; col_q <= '0;
    end else if (cmd_i.load) begin
      col_q <= line_color_i;
      if ((WB'(bx_s) - WB'(ax_s)) >= (WB'(by_s) - WB'(ay_s))) begin
        fx_q <= ax_s; fy_q <= ay_s; sx_q <= bx_s; sy_q <= by_s;
        phase_q <= PHASE_ONE;
        pos_q <= (CoordBits + 1)'(ay_s);
      end else begin
        fx_q <= bx_s; fy_q <= by_s; sx_q <= ax_s; sy_q <= ay_s;
        phase_q <= PHASE_TWO;
        pos_q <= (CoordBits + 1)'(bx_s) + 1'b1;
      end
    end else if (cmd_i.advance) begin
      phase_q <= phase_d;
      if (phase_q == PHASE_ONE) begin
        if (cur_w <= WB'(sy_q)) begin
          if (fx_q > sx_q) begin
            fx_q <= sx_q; fy_q <= sy_q; sx_q <= fx_q; sy_q <= fy_q;
            pos_q <= (CoordBits + 1)'(sx_q) + 1'b1;
          end else begin
            pos_q <= (CoordBits + 1)'(fx_q) + 1'b1;
          end
        end else begin
          pos_q <= pos_q - 1'b1;
        end
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    fin_w   = 1'b0;
    unique case (phase_q)
      PHASE_ONE: begin
        if (cur_w <= WB'(sy_q)) begin
          if (fx_q == sx_q) begin
            phase_d = PHASE_IDLE; fin_w = 1'b1;
          end else begin
            phase_d = PHASE_TWO;
          end
        end
      end
      PHASE_TWO: begin
        if (cur_w >= WB'(sx_q)) begin
          phase_d = PHASE_IDLE; fin_w = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign sts_o.div_done = done_q;
  assign sts_o.fin      = fin_w;
  assign sts_o.phase    = phase_q;

  // pixel coordinates, captured together with the walk update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
    end else if (cmd_i.advance) begin
      if (phase_q == PHASE_ONE) begin
        px_q <= CoordBits'(res_w);
        py_q <= CoordBits'(pos_q);
      end else begin
        px_q <= CoordBits'(pos_q);
        py_q <= CoordBits'(res_w);
      end
    end
  end

  assign px_o          = px_q;
  assign py_o          = py_q;
  assign pixel_color_o = col_q;
endmodule

### rtl/line_raster_interpolating.sv
// Interpolating line rasterizer: top level and its control state machine.
// Depends on lri_pkg and lri_datapath.
// A step item is accepted while idle; the divider then yields its 28 quotient bits,
// one per cycle, and the pixel is committed when the divider is done; a start item is
// loaded on acceptance and leaves the block idle. One item is handled at a time; the next
// item is accepted the cycle after the pixel is taken. Reset: async active low.
module line_raster_interpolating #(
  parameter int unsigned CoordBits = lri_pkg::CoordBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic signed [CoordBits-1:0]    ax_i,
  input  logic signed [CoordBits-1:0]    ay_i,
  input  logic signed [CoordBits-1:0]    bx_i,
  input  logic signed [CoordBits-1:0]    by_i,
  input  logic [lri_pkg::ColorBits-1:0]  line_color_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [CoordBits-1:0]    px_o,
  output logic signed [CoordBits-1:0]    py_o,
  output logic [lri_pkg::ColorBits-1:0]  pixel_color_o,
  output logic                           last_o
);
  import lri_pkg::*;

  // commands down to the datapath, status back up
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // controller: handshakes, sequencing of load / divide / commit
  lri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .last_o      (last_o),
    .dp_cmd_o    (dp_cmd),
    .dp_sts_i    (dp_sts)
  );

  // datapath: endpoints, walk position, divider, pixel registers
  lri_datapath #(.CoordBits(CoordBits)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .ax_i          (ax_i),
    .ay_i          (ay_i),
    .bx_i          (bx_i),
    .by_i          (by_i),
    .line_color_i  (line_color_i),
    .px_o          (px_o),
    .py_o          (py_o),
    .pixel_color_o (pixel_color_o)
  );
endmodule

// Control state machine: idle takes items, div waits on the divider,
// out holds the pixel until it is taken.
module lri_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             last_o,
  output lri_pkg::dp_cmd_t dp_cmd_o,
  input  lri_pkg::dp_sts_t dp_sts_i
);
  import lri_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   last_q;
  logic   in_acc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign last_o      = last_q;
  assign in_acc      = in_valid_i && !in_stall_o;

  // a step while idle is taken and yields nothing
  always_comb begin
    dp_cmd_o.load      = in_acc && (cmd_i == CmdStart);
    dp_cmd_o.div_start = in_acc && (cmd_i == CmdStep) && (dp_sts_i.phase != PHASE_IDLE);
    dp_cmd_o.advance   = (state_q == ST_DIV) && dp_sts_i.div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (dp_cmd_o.div_start) state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (dp_sts_i.div_done) begin
            state_q <= ST_OUT;
            last_q  <= dp_sts_i.fin;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

### verif/tb_line_raster_interpolating.sv
// Testbench for line_raster_interpolating: directed and random start/step items,
// checked pixel by pixel against a behavioral line walker kept in this file.
// Depends on rtl/lri_pkg.sv, rtl/lri_datapath.sv and rtl/line_raster_interpolating.sv.
module tb_line_raster_interpolating;
  timeunit 1ns;
  timeprecision 1ps;
  import lri_pkg::*;

  localparam int unsigned CB = CoordBits;
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    logic                 cmd;
    coord_t               ax, ay, bx, by;
    logic [ColorBits-1:0] color;
  } line_item_t;

  typedef struct {
    coord_t               x, y;
    logic [ColorBits-1:0] color;
    logic                 last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // item side
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 cmd_i = 1'b0;
  coord_t               ax_i = '0, ay_i = '0, bx_i = '0, by_i = '0;
  logic [ColorBits-1:0] line_color_i = '0;
  // pixel side
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b1;
  coord_t               px_o, py_o;
  logic [ColorBits-1:0] pixel_color_o;
  logic                 last_o;

  line_raster_interpolating i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .cmd_i, .ax_i, .ay_i, .bx_i, .by_i, .line_color_i,
    .out_valid_o, .out_stall_i, .px_o, .py_o, .pixel_color_o, .last_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  line_item_t items_to_send[$];
  pixel_t     pixels_due[$];
  int         n_errors = 0;
  int         n_pixels = 0;
  bit         steady_mode = 0;  // when set, neither side idles

  // ---------------------------------------------------------------
  // Line walker: mirrors the block's state, yields the expected pixel
  // ---------------------------------------------------------------
  phase_e               w_phase = PHASE_IDLE;
  int                   w_fx = 0, w_fy = 0, w_sx = 0, w_sy = 0, w_pos = 0;
  logic [ColorBits-1:0] w_color = '0;

  // base + num*off/den, truncating toward zero, zero divisor taken as 1
  function automatic int lerp(int base, int num, int den, int off);
    longint d;
    d = (den == 0) ? longint'(1) : longint'(den);
    return base + int'((longint'(num) * longint'(off)) / d);
  endfunction

  task automatic walk_item(input line_item_t it);
    int     x, y, t;
    bit     fin;
    pixel_t p;
    fin = 0;
    if (it.cmd == CMD_START) begin
      w_fx = int'(it.ax); w_fy = int'(it.ay); w_sx = int'(it.bx); w_sy = int'(it.by);
      // first endpoint gets the larger y
      if (w_fy < w_sy) begin
        t = w_fx; w_fx = w_sx; w_sx = t;
        t = w_fy; w_fy = w_sy; w_sy = t;
      end
      w_color = it.color;
      if ((w_sx - w_fx) >= (w_sy - w_fy)) begin
        w_phase = PHASE_ONE;
        w_pos   = w_fy;
      end else begin
        // dx < 0: reorder by x and go straight to the x walk
        t = w_fx; w_fx = w_sx; w_sx = t;
        t = w_fy; w_fy = w_sy; w_sy = t;
        w_phase = PHASE_TWO;
        w_pos   = w_fx + 1;
      end
      return;
    end
    case (w_phase)
      PHASE_ONE: begin
        y = w_pos;
        x = lerp(w_fx, w_sx - w_fx, w_sy - w_fy, y - w_fy);
        if (y <= w_sy) begin
          if (w_fx > w_sx) begin
            t = w_fx; w_fx = w_sx; w_sx = t;
            t = w_fy; w_fy = w_sy; w_sy = t;
          end
          if (w_fx == w_sx) begin
            w_phase = PHASE_IDLE;
            fin = 1;
          end else begin
            w_phase = PHASE_TWO;
            w_pos   = w_fx + 1;
          end
        end else begin
          w_pos = y - 1;
        end
      end
      PHASE_TWO: begin
        x = w_pos;
        y = lerp(w_fy, w_sy - w_fy, w_sx - w_fx, x - w_fx);
        if (x >= w_sx) begin
          w_phase = PHASE_IDLE;
          fin = 1;
        end else begin
          w_pos = x + 1;
        end
      end
      default: return;  // step while idle: nothing comes out
    endcase
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.color = w_color;
    p.last = fin;
    pixels_due.push_back(p);
  endtask

  // ---------------------------------------------------------------
  // Driver: presents queued items, random gap after each one
  // ---------------------------------------------------------------
  line_item_t cur_item;
  int         send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) walk_item(cur_item);
      // payload may only move when nothing is held under stall
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (items_to_send.size() > 0) begin
          cur_item = items_to_send.pop_front();
          cmd_i        <= cur_item.cmd;
          ax_i         <= cur_item.ax;
          ay_i         <= cur_item.ay;
          bx_i         <= cur_item.bx;
          by_i         <= cur_item.by;
          line_color_i <= cur_item.color;
          in_valid_i   <= 1'b1;
          if ($urandom_range(0, 19) == 0) steady_mode = !steady_mode;
          send_gap = steady_mode ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Monitor: takes pixels, stalls at random, one long hold-off
  // ---------------------------------------------------------------
  int  stall_left = 0;
  bit  long_hold_done = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_pixels++;
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
                   px_o, py_o, pixel_color_o, last_o);
          n_errors++;
        end else begin
          e = pixels_due.pop_front();
          if (px_o !== e.x) begin
            $display("%0t: px expected %0d actual %0d", $time, e.x, px_o);
            n_errors++;
          end
          if (py_o !== e.y) begin
            $display("%0t: py expected %0d actual %0d", $time, e.y, py_o);
            n_errors++;
          end
          if (pixel_color_o !== e.color) begin
            $display("%0t: pixel_color expected %h actual %h", $time, e.color,
                     pixel_color_o);
            n_errors++;
          end
          if (last_o !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, last_o);
            n_errors++;
          end
        end
        // long hold-off once, so the sender backs up behind the block
        if (!long_hold_done && n_pixels == 150) begin
          long_hold_done = 1;
          stall_left = 400;
        end else begin
          stall_left = steady_mode ? 0 : $urandom_range(0, 8);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  task automatic add_start(int ax, int ay, int bx, int by, logic [ColorBits-1:0] c);
    line_item_t it;
    it.cmd = CMD_START;
    it.ax = coord_t'(ax); it.ay = coord_t'(ay);
    it.bx = coord_t'(bx); it.by = coord_t'(by);
    it.color = c;
    items_to_send.push_back(it);
  endtask

  // step items carry random junk in the unused fields
  task automatic add_steps(int n);
    line_item_t it;
    repeat (n) begin
      it.cmd = CMD_STEP;
      it.ax = coord_t'($urandom); it.ay = coord_t'($urandom);
      it.bx = coord_t'($urandom); it.by = coord_t'($urandom);
      it.color = ColorBits'($urandom);
      items_to_send.push_back(it);
    end
  endtask

  function automatic int clampc(int v);
    int lo, hi;
    lo = -(1 << (CB - 1));
    hi = (1 << (CB - 1)) - 1;
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  initial begin
    int ax, ay, bx, by, n, kind;
    int lo, hi;
    lo = -(1 << (CB - 1));
    hi = (1 << (CB - 1)) - 1;

    // directed
    add_steps(1);                                  // step while idle
    add_start(lo, hi, lo + 3, hi, '0);             // equal y: one pass-one pixel
    add_steps(4);
    add_start(hi, lo, hi, lo + 3, 24'hFFFFFF);     // equal x: pass two empty
    add_steps(4);
    add_start(10, 3, 0, 0, 24'h5A5A5A);            // pass one skipped
    add_steps(11);
    add_steps(1);                                  // step after the line ended
    add_start(lo, hi, hi, lo, 24'hA5A5A5);         // full-span line, abandoned
    add_steps(3);
    add_start(hi, hi, lo, lo, 24'h123456);         // restart while busy
    add_steps(2);

    // random: mostly complete short lines anywhere in the plane
    while (items_to_send.size() < 1550) begin
      kind = $urandom_range(0, 99);
      ax = int'(coord_t'($urandom));
      ay = int'(coord_t'($urandom));
      bx = clampc(ax + $urandom_range(0, 16) - 8);
      by = clampc(ay + $urandom_range(0, 16) - 8);
      n  = (bx > ax ? bx - ax : ax - bx) + (by > ay ? by - ay : ay - by) + 1;
      if (kind < 80) begin
        add_start(ax, ay, bx, by, ColorBits'($urandom));
        add_steps(n);
      end else if (kind < 90) begin
        add_start(ax, ay, bx, by, ColorBits'($urandom));
        add_steps($urandom_range(0, n));           // abandoned or left hanging
      end else begin
        add_steps($urandom_range(1, 3));           // noise
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (items_to_send.size() != 0 || in_valid_i || pixels_due.size() != 0);
    repeat (60) @(posedge clk_i);
    if (pixels_due.size() != 0 || out_valid_o) begin
      $display("%0t: %0d pixels still expected", $time, pixels_due.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("[line_raster_interpolating] OK");
    end else begin
      $display("[line_raster_interpolating] ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[line_raster_interpolating] ERROR");
    $finish;
  end
endmodule
